// ===== design/fmeg_pkg.sv =====
`default_nettype none

package fmeg_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;

    typedef logic [1:0] stage_t;
    typedef logic [1:0] kind_t;
    typedef logic [1:0] ksl_mode_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam stage_t STAGE_ATTACK  = 2'd0;
    localparam stage_t STAGE_DECAY   = 2'd1;
    localparam stage_t STAGE_SUSTAIN = 2'd2;
    localparam stage_t STAGE_RELEASE = 2'd3;

    localparam kind_t KIND_TICK    = 2'd0;
    localparam kind_t KIND_KEY_ON  = 2'd1;
    localparam kind_t KIND_KEY_OFF = 2'd2;

    localparam ksl_mode_t KSL_MODE_OFF    = 2'd0;
    localparam ksl_mode_t KSL_MODE_DOUBLE = 2'd1;
    localparam ksl_mode_t KSL_MODE_SINGLE = 2'd2;
    localparam ksl_mode_t KSL_MODE_QUAD   = 2'd3;

    localparam cfg_index_t REG_LEVEL_SCALING   = 3'd0;
    localparam cfg_index_t REG_ATTACK_DECAY    = 3'd1;
    localparam cfg_index_t REG_SUSTAIN_RELEASE = 3'd2;
    localparam cfg_index_t REG_FREQ_NUMBER     = 3'd3;
    localparam cfg_index_t REG_OCTAVE_BLOCK    = 3'd4;
    localparam cfg_index_t REG_KEY_SCALE_RATE  = 3'd5;
    localparam cfg_index_t REG_NOTE_SELECT     = 3'd6;
    localparam cfg_index_t REG_DEEP_TREMOLO    = 3'd7;

    localparam logic [8:0]  SILENCE       = 9'd511;
    localparam logic [6:0]  RATE_CAP      = 7'd60;
    localparam logic [5:0]  TREMOLO_PEAK  = 6'd26;
    localparam logic [5:0]  TREMOLO_FOLD  = 6'd51;
    localparam logic [7:0]  KSL_OFFSET    = 8'd64;
    localparam logic [3:0]  RATE_INSTANT  = 4'd15;
    localparam logic [3:0]  SUSTAIN_ALL   = 4'd15;
    localparam logic [4:0]  SUSTAIN_FLOOR = 5'd31;

    function automatic logic [6:0] ksl_base(input logic [3:0] idx);
        logic [6:0] v;
        case (idx)
            4'd0:    v = 7'd0;
            4'd1:    v = 7'd32;
            4'd2:    v = 7'd40;
            4'd3:    v = 7'd45;
            4'd4:    v = 7'd48;
            4'd5:    v = 7'd51;
            4'd6:    v = 7'd53;
            4'd7:    v = 7'd55;
            4'd8:    v = 7'd56;
            4'd9:    v = 7'd58;
            4'd10:   v = 7'd59;
            4'd11:   v = 7'd60;
            4'd12:   v = 7'd61;
            4'd13:   v = 7'd62;
            4'd14:   v = 7'd63;
            default: v = 7'd64;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== design/fm_operator_envelope_generator.sv =====
// Channel   Direction  Handshake              Payload
// cfg       in         cfg_valid / cfg_ready  cfg_index[2:0], cfg_data[9:0]
// s         in         s_valid / s_ready      s_kind, s_sustain_hold, s_tremolo_enable,
//                                             s_tremolo_position
// m         out        m_valid / m_ready      m_attenuation, m_stage_now
//
// One word per cycle sustained unless m stalls; a word passes both registers to m.
// An input register feeds one pass of envelope logic that updates stage, level and
// phase counter and loads the result register in the same cycle.
// aresetn (synchronous) empties both registers, sets release at silence, clears config.
// A stall on m holds both registers; s_ready drops only while both are full.
// cfg_ready is always high.
`default_nettype none

module fm_operator_envelope_generator (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [9:0]  cfg_data,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_kind,
    input  wire logic        s_sustain_hold,
    input  wire logic        s_tremolo_enable,
    input  wire logic [13:0] s_tremolo_position,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [8:0]       m_attenuation,
    output logic [1:0]       m_stage_now
);

    logic [7:0]  level_scaling_reg;
    logic [7:0]  attack_decay_reg;
    logic [7:0]  sustain_release_reg;
    logic [9:0]  freq_number_reg;
    logic [2:0]  octave_block_reg;
    logic        key_scale_rate_reg;
    logic        note_select_reg;
    logic        deep_tremolo_reg;

    logic        in_valid_reg;
    logic [1:0]  kind_reg;
    logic        hold_reg;
    logic        trem_en_reg;
    logic [5:0]  trem_pos_reg;

    fmeg_pkg::stage_t stage_reg, stage_next;
    logic [8:0]  level_reg, level_next;
    logic [14:0] counter_reg, counter_next;

    logic        out_valid_reg;
    logic [8:0]  atten_reg, atten_next;
    fmeg_pkg::stage_t out_stage_reg;

    logic        out_free;
    logic        fire;

    logic [3:0]  ar, dr, rr, sl_raw, rate_sel;
    logic [4:0]  sl;
    logic        ksn_bit;
    logic [3:0]  ksn;
    logic [6:0]  eff_raw;
    logic [5:0]  eff;
    logic [17:0] step;
    logic [17:0] ctr_sum;
    logic [2:0]  ovf;
    logic [11:0] prod;
    logic [8:0]  attack_level;
    logic [9:0]  lin_sum;
    logic [8:0]  lin_level;
    logic        ctr_adv;
    logic [7:0]  ksl_sum;
    logic [7:0]  ksl_v;
    logic [7:0]  ksl_add;
    logic [5:0]  am_fold;
    logic [4:0]  am;
    logic [10:0] total;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_ready;
    assign fire      = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || out_free;

    assign m_valid       = out_valid_reg;
    assign m_attenuation = atten_reg;
    assign m_stage_now   = out_stage_reg;

    always_comb begin
        ar     = attack_decay_reg[7:4];
        dr     = attack_decay_reg[3:0];
        sl_raw = sustain_release_reg[7:4];
        rr     = sustain_release_reg[3:0];
        sl     = (sl_raw == fmeg_pkg::SUSTAIN_ALL) ? fmeg_pkg::SUSTAIN_FLOOR : {1'b0, sl_raw};

        case (stage_reg)
            fmeg_pkg::STAGE_ATTACK: rate_sel = ar;
            fmeg_pkg::STAGE_DECAY:  rate_sel = dr;
            default:                rate_sel = rr;
        endcase

        ksn_bit = note_select_reg ? freq_number_reg[8] : freq_number_reg[9];
        ksn     = key_scale_rate_reg ? {octave_block_reg, ksn_bit}
                                     : {2'b00, octave_block_reg[2:1]};
        eff_raw = {3'b000, ksn} + {1'b0, rate_sel, 2'b00};
        eff     = (eff_raw > fmeg_pkg::RATE_CAP) ? fmeg_pkg::RATE_CAP[5:0] : eff_raw[5:0];
        step    = {15'd0, 1'b1, eff[1:0]} << eff[5:2];
        ctr_sum = {3'b000, counter_reg} + step;
        ovf     = (rate_sel == 4'd0) ? 3'd0 : ctr_sum[17:15];

        prod         = level_reg * ovf;
        attack_level = level_reg - prod[11:3] - 9'd1;
        lin_sum      = {1'b0, level_reg} + {7'd0, ovf};
        lin_level    = (lin_sum > {1'b0, fmeg_pkg::SILENCE}) ? fmeg_pkg::SILENCE : lin_sum[8:0];

        stage_next = stage_reg;
        level_next = level_reg;
        ctr_adv    = 1'b0;

        case (kind_reg)
            fmeg_pkg::KIND_KEY_ON:  stage_next = fmeg_pkg::STAGE_ATTACK;
            fmeg_pkg::KIND_KEY_OFF: stage_next = fmeg_pkg::STAGE_RELEASE;
            default: begin
                case (stage_reg)
                    fmeg_pkg::STAGE_ATTACK: begin
                        if (level_reg == 9'd0) begin
                            stage_next = fmeg_pkg::STAGE_DECAY;
                        end else if (ar == fmeg_pkg::RATE_INSTANT) begin
                            level_next = 9'd0;
                        end else begin
                            ctr_adv = 1'b1;
                            if (ovf != 3'd0) begin
                                level_next = attack_level;
                            end
                        end
                    end
                    fmeg_pkg::STAGE_DECAY: begin
                        if (level_reg[8:4] >= sl) begin
                            stage_next = fmeg_pkg::STAGE_SUSTAIN;
                        end else begin
                            ctr_adv    = 1'b1;
                            level_next = lin_level;
                        end
                    end
                    fmeg_pkg::STAGE_SUSTAIN: begin
                        if (!hold_reg) begin
                            stage_next = fmeg_pkg::STAGE_RELEASE;
                        end
                    end
                    default: begin
                        ctr_adv    = 1'b1;
                        level_next = lin_level;
                    end
                endcase
            end
        endcase

        counter_next = (ctr_adv && rate_sel != 4'd0) ? ctr_sum[14:0] : counter_reg;

        ksl_sum = {1'b0, fmeg_pkg::ksl_base(freq_number_reg[9:6])}
                + {2'b00, octave_block_reg, 3'b000};
        ksl_v   = (ksl_sum > fmeg_pkg::KSL_OFFSET) ? ksl_sum - fmeg_pkg::KSL_OFFSET : 8'd0;
        case (level_scaling_reg[7:6])
            fmeg_pkg::KSL_MODE_OFF:    ksl_add = 8'd0;
            fmeg_pkg::KSL_MODE_DOUBLE: ksl_add = {ksl_v[6:0], 1'b0};
            fmeg_pkg::KSL_MODE_QUAD:   ksl_add = {ksl_v[5:0], 2'b00};
            default:                   ksl_add = ksl_v;
        endcase

        if (trem_pos_reg > fmeg_pkg::TREMOLO_FOLD) begin
            am_fold = 6'd0;
        end else if (trem_pos_reg > fmeg_pkg::TREMOLO_PEAK) begin
            am_fold = fmeg_pkg::TREMOLO_FOLD - trem_pos_reg;
        end else begin
            am_fold = trem_pos_reg;
        end
        if (!trem_en_reg) begin
            am = 5'd0;
        end else if (deep_tremolo_reg) begin
            am = am_fold[4:0];
        end else begin
            am = {2'b00, am_fold[4:2]};
        end

        total = {2'b00, level_next} + {1'b0, level_scaling_reg[5:0], 2'b00}
              + {3'b000, ksl_add} + {6'd0, am};
        atten_next = (total > {2'b00, fmeg_pkg::SILENCE}) ? fmeg_pkg::SILENCE : total[8:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_scaling_reg   <= '0;
            attack_decay_reg    <= '0;
            sustain_release_reg <= '0;
            freq_number_reg     <= '0;
            octave_block_reg    <= '0;
            key_scale_rate_reg  <= 1'b0;
            note_select_reg     <= 1'b0;
            deep_tremolo_reg    <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                fmeg_pkg::REG_LEVEL_SCALING:   level_scaling_reg   <= cfg_data[7:0];
                fmeg_pkg::REG_ATTACK_DECAY:    attack_decay_reg    <= cfg_data[7:0];
                fmeg_pkg::REG_SUSTAIN_RELEASE: sustain_release_reg <= cfg_data[7:0];
                fmeg_pkg::REG_FREQ_NUMBER:     freq_number_reg     <= cfg_data;
                fmeg_pkg::REG_OCTAVE_BLOCK:    octave_block_reg    <= cfg_data[2:0];
                fmeg_pkg::REG_KEY_SCALE_RATE:  key_scale_rate_reg  <= cfg_data[0];
                fmeg_pkg::REG_NOTE_SELECT:     note_select_reg     <= cfg_data[0];
                fmeg_pkg::REG_DEEP_TREMOLO:    deep_tremolo_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            stage_reg     <= fmeg_pkg::STAGE_RELEASE;
            level_reg     <= fmeg_pkg::SILENCE;
            counter_reg   <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
                stage_reg     <= stage_next;
                level_reg     <= level_next;
                counter_reg   <= counter_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            kind_reg     <= s_kind;
            hold_reg     <= s_sustain_hold;
            trem_en_reg  <= s_tremolo_enable;
            trem_pos_reg <= s_tremolo_position[13:8];
        end
        if (fire) begin
            atten_reg     <= atten_next;
            out_stage_reg <= stage_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/fmeg_checker.sv =====
`default_nettype none

module fmeg_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [8:0] m_attenuation,
    input wire logic [1:0] m_stage_now
);

    // drop the result word during reset
    a_reset_empties: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // hold back input only while the result side is full and stalled
    a_ready_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("s_ready low without an output stall");

    // a stalled result word stays put
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_attenuation)
                                   && $stable(m_stage_now)))
        else $error("result word changed while stalled");

    // an accepted input word always reaches the output while m_ready stays high
    a_input_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && m_ready) ##1 m_ready |=> m_valid)
        else $error("accepted word did not reach the output");

endmodule

bind fm_operator_envelope_generator fmeg_checker u_fmeg_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_attenuation (m_attenuation),
    .m_stage_now   (m_stage_now)
);

`default_nettype wire

// ===== tb/fm_envelope_checker.sv =====
module fm_envelope_checker (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [9:0]  cfg_data,

    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic        s_sustain_hold,
    input  logic        s_tremolo_enable,
    input  logic [13:0] s_tremolo_position,

    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [8:0]  m_attenuation,
    input  logic [1:0]  m_stage_now,

    output int          errors,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FULL_SCALE = 511;
    localparam int TREM_PEAK  = 26;
    localparam int RATE_LIMIT = 60;

    typedef struct packed {
        logic [8:0]       attenuation;
        fmeg_pkg::stage_t stage;
    } envelope_out_t;

    int ksl_rom [16] = '{0, 32, 40, 45, 48, 51, 53, 55, 56, 58, 59, 60, 61, 62, 63, 64};

    logic [7:0]  lvl_scale;
    logic [7:0]  atk_dec;
    logic [7:0]  sus_rel;
    logic [9:0]  fnum;
    logic [2:0]  block;
    logic        ksr_full;
    logic        note_sel;
    logic        deep_trem;

    fmeg_pkg::stage_t env_stage;
    logic [8:0]  env_level;
    logic [14:0] phase_acc;

    envelope_out_t expected_envelope [$];

    initial errors = 0;

    task automatic phase_overflow(input logic [3:0] rate, output logic [2:0] ovf);
        logic [3:0] ksn;
        int eff;
        int sum;
        ovf = 3'd0;
        if (rate != 4'd0) begin
            ksn = {block, note_sel ? fnum[8] : fnum[9]};
            if (!ksr_full) begin
                ksn = ksn >> 2;
            end
            eff = int'(ksn) + int'(rate) * 4;
            if (eff > RATE_LIMIT) begin
                eff = RATE_LIMIT;
            end
            sum = int'(phase_acc) + ((4 + eff % 4) << (eff / 4));
            ovf = 3'(sum >> 15);
            phase_acc = 15'(sum);
        end
    endtask

    always @(posedge aclk) begin : watch
        envelope_out_t want;
        logic [2:0]    ovf;
        logic [4:0]    sustain_floor;
        logic [3:0]    lin_rate;
        logic          linear;
        int            total;
        int            ksl;
        int            am;
        if (!aresetn) begin
            lvl_scale = '0;
            atk_dec   = '0;
            sus_rel   = '0;
            fnum      = '0;
            block     = '0;
            ksr_full  = 1'b0;
            note_sel  = 1'b0;
            deep_trem = 1'b0;
            env_stage = fmeg_pkg::STAGE_RELEASE;
            env_level = 9'(FULL_SCALE);
            phase_acc = '0;
            expected_envelope.delete();
            outstanding <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    fmeg_pkg::REG_LEVEL_SCALING:   lvl_scale = cfg_data[7:0];
                    fmeg_pkg::REG_ATTACK_DECAY:    atk_dec   = cfg_data[7:0];
                    fmeg_pkg::REG_SUSTAIN_RELEASE: sus_rel   = cfg_data[7:0];
                    fmeg_pkg::REG_FREQ_NUMBER:     fnum      = cfg_data;
                    fmeg_pkg::REG_OCTAVE_BLOCK:    block     = cfg_data[2:0];
                    fmeg_pkg::REG_KEY_SCALE_RATE:  ksr_full  = cfg_data[0];
                    fmeg_pkg::REG_NOTE_SELECT:     note_sel  = cfg_data[0];
                    fmeg_pkg::REG_DEEP_TREMOLO:    deep_trem = cfg_data[0];
                    default: ;
                endcase
            end

            if (m_valid && m_ready) begin
                if (expected_envelope.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word, attenuation %0d stage %0d",
                             $time, m_attenuation, m_stage_now);
                end else begin
                    want = expected_envelope.pop_front();
                    if (m_attenuation !== want.attenuation) begin
                        errors++;
                        $display("%0t: attenuation expected %0d actual %0d",
                                 $time, want.attenuation, m_attenuation);
                    end
                    if (m_stage_now !== want.stage) begin
                        errors++;
                        $display("%0t: stage expected %0d actual %0d",
                                 $time, want.stage, m_stage_now);
                    end
                end
            end

            if (s_valid && s_ready) begin
                sustain_floor = (sus_rel[7:4] == fmeg_pkg::SUSTAIN_ALL) ? 5'd31
                                                                       : {1'b0, sus_rel[7:4]};
                linear = 1'b0;
                lin_rate = sus_rel[3:0];
                case (s_kind)
                    fmeg_pkg::KIND_KEY_ON:  env_stage = fmeg_pkg::STAGE_ATTACK;
                    fmeg_pkg::KIND_KEY_OFF: env_stage = fmeg_pkg::STAGE_RELEASE;
                    default: begin
                        case (env_stage)
                            fmeg_pkg::STAGE_ATTACK: begin
                                if (env_level == 9'd0) begin
                                    env_stage = fmeg_pkg::STAGE_DECAY;
                                end else if (atk_dec[7:4] == fmeg_pkg::RATE_INSTANT) begin
                                    env_level = 9'd0;
                                end else begin
                                    phase_overflow(atk_dec[7:4], ovf);
                                    if (ovf != 3'd0) begin
                                        env_level = env_level -
                                            9'(((int'(env_level) * int'(ovf)) >> 3) + 1);
                                    end
                                end
                            end
                            fmeg_pkg::STAGE_DECAY: begin
                                if (env_level[8:4] >= sustain_floor) begin
                                    env_stage = fmeg_pkg::STAGE_SUSTAIN;
                                end else begin
                                    linear = 1'b1;
                                    lin_rate = atk_dec[3:0];
                                end
                            end
                            fmeg_pkg::STAGE_SUSTAIN: begin
                                if (!s_sustain_hold) begin
                                    env_stage = fmeg_pkg::STAGE_RELEASE;
                                end
                            end
                            default: linear = 1'b1;
                        endcase
                    end
                endcase

                if (linear) begin
                    phase_overflow(lin_rate, ovf);
                    total = int'(env_level) + int'(ovf);
                    env_level = (total > FULL_SCALE) ? 9'(FULL_SCALE) : 9'(total);
                end

                ksl = 0;
                if (lvl_scale[7:6] != fmeg_pkg::KSL_MODE_OFF) begin
                    ksl = ksl_rom[fnum[9:6]] + 8 * (int'(block) - 8);
                    if (ksl < 0) begin
                        ksl = 0;
                    end else if (lvl_scale[7:6] == fmeg_pkg::KSL_MODE_DOUBLE) begin
                        ksl = ksl * 2;
                    end else if (lvl_scale[7:6] == fmeg_pkg::KSL_MODE_QUAD) begin
                        ksl = ksl * 4;
                    end
                end

                total = int'(env_level) + int'(lvl_scale[5:0]) * 4 + ksl;
                if (s_tremolo_enable) begin
                    am = int'(s_tremolo_position[13:8]);
                    if (am > TREM_PEAK) begin
                        am = 2 * TREM_PEAK - 1 - am;
                    end
                    if (am < 0) begin
                        am = 0;
                    end
                    if (!deep_trem) begin
                        am = am / 4;
                    end
                    total += am;
                end

                want.attenuation = (total > FULL_SCALE) ? 9'(FULL_SCALE) : 9'(total);
                want.stage = env_stage;
                expected_envelope.push_back(want);
            end

            outstanding <= expected_envelope.size();
        end
    end

endmodule

// ===== tb/fm_operator_envelope_generator_tb.sv =====
module fm_operator_envelope_generator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam fmeg_pkg::kind_t KIND_SPARE  = 2'd3;
    localparam int              CYCLE_LIMIT = 600000;
    localparam int              WORD_TARGET = 1650;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [9:0]  cfg_data = '0;

    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_kind = '0;
    logic        s_sustain_hold = 1'b0;
    logic        s_tremolo_enable = 1'b0;
    logic [13:0] s_tremolo_position = '0;

    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [8:0]  m_attenuation;
    logic [1:0]  m_stage_now;

    int          mismatch_count;
    int          words_in_flight;
    int unsigned words_sent = 0;
    int unsigned cycles = 0;
    int unsigned ready_hold = 0;
    bit          source_gaps = 1'b1;
    bit          sink_stalls = 1'b1;

    fm_operator_envelope_generator u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_kind             (s_kind),
        .s_sustain_hold     (s_sustain_hold),
        .s_tremolo_enable   (s_tremolo_enable),
        .s_tremolo_position (s_tremolo_position),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_attenuation      (m_attenuation),
        .m_stage_now        (m_stage_now)
    );

    fm_envelope_checker u_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_kind             (s_kind),
        .s_sustain_hold     (s_sustain_hold),
        .s_tremolo_enable   (s_tremolo_enable),
        .s_tremolo_position (s_tremolo_position),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_attenuation      (m_attenuation),
        .m_stage_now        (m_stage_now),
        .errors             (mismatch_count),
        .outstanding        (words_in_flight)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int unsigned pause_len();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(4, 40);
    endfunction

    always @(posedge aclk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
            m_ready <= 1'b0;
            ready_hold <= pause_len() - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic put_reg(input fmeg_pkg::cfg_index_t idx, input logic [9:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic program_voice(input logic [9:0] ls, input logic [9:0] ad,
                                 input logic [9:0] sr, input logic [9:0] fn,
                                 input logic [9:0] blk, input logic [9:0] ksr,
                                 input logic [9:0] nsel, input logic [9:0] deep);
        put_reg(fmeg_pkg::REG_LEVEL_SCALING, ls);
        put_reg(fmeg_pkg::REG_ATTACK_DECAY, ad);
        put_reg(fmeg_pkg::REG_SUSTAIN_RELEASE, sr);
        put_reg(fmeg_pkg::REG_FREQ_NUMBER, fn);
        put_reg(fmeg_pkg::REG_OCTAVE_BLOCK, blk);
        put_reg(fmeg_pkg::REG_KEY_SCALE_RATE, ksr);
        put_reg(fmeg_pkg::REG_NOTE_SELECT, nsel);
        put_reg(fmeg_pkg::REG_DEEP_TREMOLO, deep);
        cfg_valid <= 1'b0;
    endtask

    // hold off until every word sent has come back
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (words_in_flight != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic send_word(input fmeg_pkg::kind_t kind, input logic hold, input logic trem,
                             input logic [13:0] pos);
        int unsigned gap;
        gap = (source_gaps && $urandom_range(0, 2) == 0) ? pause_len() : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid            <= 1'b1;
        s_kind             <= kind;
        s_sustain_hold     <= hold;
        s_tremolo_enable   <= trem;
        s_tremolo_position <= pos;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
    endtask

    task automatic send_random(input fmeg_pkg::kind_t kind);
        logic [13:0] pos;
        pos = ($urandom_range(0, 7) == 0) ? 14'($urandom) : 14'($urandom_range(0, 13311));
        send_word(kind, $urandom_range(0, 3) != 0, 1'($urandom), pos);
    endtask

    initial begin
        int unsigned budget;
        int unsigned ticks;
        int          phase;
        logic [3:0]  atk;
        logic [3:0]  dec;
        logic [3:0]  sus;
        logic [3:0]  rel;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // settings after reset: all rates zero
        send_word(fmeg_pkg::KIND_TICK, 1'b1, 1'b0, 14'h0000);
        send_word(fmeg_pkg::KIND_KEY_ON, 1'b0, 1'b1, 14'h3fff);
        send_word(fmeg_pkg::KIND_TICK, 1'b0, 1'b1, 14'h1a00);
        send_word(KIND_SPARE, 1'b1, 1'b0, 14'h0000);
        send_word(fmeg_pkg::KIND_KEY_OFF, 1'b0, 1'b0, 14'h3300);
        settle();

        // instant attack, decay rate zero, everything else at its maximum
        program_voice(10'h3ff, 10'h0f0, 10'h0ff, 10'h3ff, 10'd7, 10'd1, 10'd1, 10'd1);
        send_word(fmeg_pkg::KIND_KEY_ON, 1'b1, 1'b0, 14'h0000);
        send_word(fmeg_pkg::KIND_TICK, 1'b1, 1'b0, 14'h0000);
        send_word(fmeg_pkg::KIND_TICK, 1'b1, 1'b0, 14'h0000);
        send_word(fmeg_pkg::KIND_TICK, 1'b1, 1'b1, 14'h0000);
        send_word(fmeg_pkg::KIND_TICK, 1'b1, 1'b1, 14'h1a00);
        send_word(fmeg_pkg::KIND_TICK, 1'b1, 1'b1, 14'h1b00);
        send_word(fmeg_pkg::KIND_TICK, 1'b1, 1'b1, 14'h3300);
        send_word(fmeg_pkg::KIND_TICK, 1'b1, 1'b1, 14'h3400);
        send_word(fmeg_pkg::KIND_TICK, 1'b1, 1'b1, 14'h3fff);
        send_word(fmeg_pkg::KIND_KEY_OFF, 1'b1, 1'b0, 14'h0000);
        send_word(fmeg_pkg::KIND_TICK, 1'b0, 1'b0, 14'h0000);
        settle();

        // zero sustain level: hold in sustain, then drop to release
        program_voice(10'h040, 10'h0f0, 10'h00f, 10'h100, 10'd0, 10'd0, 10'd0, 10'd0);
        send_word(fmeg_pkg::KIND_KEY_ON, 1'b1, 1'b1, 14'h1a00);
        send_word(fmeg_pkg::KIND_TICK, 1'b1, 1'b1, 14'h1a00);
        send_word(fmeg_pkg::KIND_TICK, 1'b1, 1'b1, 14'h1a00);
        send_word(fmeg_pkg::KIND_TICK, 1'b1, 1'b1, 14'h1a00);
        send_word(fmeg_pkg::KIND_TICK, 1'b1, 1'b1, 14'h1a00);
        send_word(fmeg_pkg::KIND_TICK, 1'b0, 1'b1, 14'h1a00);
        send_word(fmeg_pkg::KIND_TICK, 1'b0, 1'b1, 14'h1a00);

        phase = 0;
        while (words_sent < WORD_TARGET) begin
            settle();
            atk = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'($urandom_range(11, 15));
            dec = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'($urandom_range(12, 15));
            rel = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'($urandom_range(12, 15));
            sus = 4'($urandom);
            if (phase == 2) begin
                program_voice(10'd0, {2'b00, atk, dec}, {2'b00, sus, rel},
                              10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
            end else begin
                program_voice(10'($urandom), {2'($urandom), atk, dec},
                              {2'($urandom), sus, rel}, 10'($urandom), 10'($urandom),
                              10'($urandom), 10'($urandom), 10'($urandom));
            end
            source_gaps = $urandom_range(0, 3) != 0;
            sink_stalls = $urandom_range(0, 3) != 0;
            budget = words_sent + $urandom_range(80, 200);
            if (budget > WORD_TARGET) begin
                budget = WORD_TARGET;
            end
            while (words_sent < budget) begin
                send_random(fmeg_pkg::KIND_KEY_ON);
                ticks = $urandom_range(4, 100);
                repeat (ticks) begin
                    send_random(($urandom_range(0, 9) == 0) ? fmeg_pkg::kind_t'($urandom)
                                                            : fmeg_pkg::KIND_TICK);
                end
                if ($urandom_range(0, 7) != 0) begin
                    send_random(fmeg_pkg::KIND_KEY_OFF);
                end
                ticks = $urandom_range(2, 60);
                repeat (ticks) send_random(fmeg_pkg::KIND_TICK);
            end
            phase++;
        end
        settle();

        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
